/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/hvt_pkg.sv */
package hvt_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int PAIR_W        = PROD_W + 1;
    localparam int SUM_W         = PROD_W + 2;
    localparam int NUM_LANES     = 4;
    localparam int LANE_IDX_W    = $clog2(NUM_LANES);
    localparam int NUM_REGS      = 8;
    localparam int CFG_IDX_W     = $clog2(NUM_REGS);
    localparam int CFG_DATA_W    = 2 * DATA_W;

    typedef logic signed [DATA_W-1:0] fix_t;
    typedef fix_t fix_vec_t [NUM_LANES];
    typedef logic signed [SUM_W-1:0] sum_t;
    typedef sum_t sum_vec_t [NUM_LANES];

    typedef enum logic [1:0] {
        OP_ROW   = 2'd0,
        OP_COL   = 2'd1,
        OP_POINT = 2'd2,
        OP_DIR   = 2'd3
    } op_t;

    typedef logic [NUM_REGS-1:0][CFG_DATA_W-1:0] mat_regs_t;

    // After reset the matrix is the identity in Q16.16.
    localparam mat_regs_t MAT_RESET = {
        64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000
    };

    localparam fix_t FIX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam fix_t FIX_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Stage enables that the top level hands to every lane.
    typedef struct packed {
        logic prod;
        logic pair;
        logic total;
    } lane_en_t;

    function automatic fix_t mat_entry(mat_regs_t regs, logic [LANE_IDX_W-1:0] r,
                                       logic [LANE_IDX_W-1:0] c);
        logic [CFG_DATA_W-1:0] word;
        word = regs[{r, c[1]}];
        return c[0] ? fix_t'(word[2*DATA_W-1:DATA_W]) : fix_t'(word[DATA_W-1:0]);
    endfunction

endpackage

/* rtl/hvt_if.sv */
interface hvt_vec_if;
    import hvt_pkg::*;

    logic valid;
    logic ready;
    op_t  operation;
    fix_t comp_x;
    fix_t comp_y;
    fix_t comp_z;
    fix_t comp_w;

    modport source (output valid, operation, comp_x, comp_y, comp_z, comp_w, input ready);
    modport sink   (input valid, operation, comp_x, comp_y, comp_z, comp_w, output ready);
endinterface

interface hvt_res_if;
    import hvt_pkg::*;

    logic valid;
    logic ready;
    fix_t res_0;
    fix_t res_1;
    fix_t res_2;
    fix_t res_3;

    modport source (output valid, res_0, res_1, res_2, res_3, input ready);
    modport sink   (input valid, res_0, res_1, res_2, res_3, output ready);
endinterface

/* rtl/homogeneous_vector_transform.sv */
// Multiplies each incoming four-component Q16.16 vector by the 4x4 matrix held in the eight
// configuration registers and returns one transaction of four saturated dot products. Four
// lanes of four 32x32 multipliers each work side by side, so a new transaction is taken
// every cycle unless a stall reaches the input. The pipeline is operand register, products,
// pair sums, total, and the output register where the lanes are shifted, saturated and
// merged. A stalled output only stops the stages behind a full stage, so the input stays
// ready while bubbles remain.
module homogeneous_vector_transform #(
    parameter int FRAC_BITS = hvt_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [hvt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hvt_pkg::CFG_DATA_W-1:0]   cfg_data,
    hvt_vec_if.sink                          vector,
    hvt_res_if.source                        result
);
    import hvt_pkg::*;

    localparam int   STAGES    = 5;
    localparam int   OUT_STAGE = STAGES - 1;
    localparam fix_t FIX_ONE   = fix_t'(DATA_W'(1) << FRAC_BITS);

    mat_regs_t         mat_reg;
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] en;
    fix_vec_t          vec_reg;
    fix_vec_t          vec_next;
    logic              col_mode_reg;
    lane_en_t          lane_en;
    sum_vec_t          totals;
    fix_vec_t          res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg <= MAT_RESET;
        end
        else if (cfg_we)
        begin
            mat_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        en[OUT_STAGE] = !valid_reg[OUT_STAGE] || result.ready;
        for (int k = OUT_STAGE - 1; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        valid_next = valid_reg;
        if (en[0])
        begin
            valid_next[0] = vector.valid;
        end
        for (int k = 1; k < STAGES; k++)
        begin
            if (en[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        vec_next[0] = vector.comp_x;
        vec_next[1] = vector.comp_y;
        vec_next[2] = vector.comp_z;
        case (vector.operation)
            OP_POINT: vec_next[3] = FIX_ONE;
            OP_DIR:   vec_next[3] = '0;
            default:  vec_next[3] = vector.comp_w;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            vec_reg      <= vec_next;
            col_mode_reg <= (vector.operation == OP_COL);
        end
    end

    assign lane_en.prod  = en[1];
    assign lane_en.pair  = en[2];
    assign lane_en.total = en[3];

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        hvt_lane #(
            .LANE_IDX (i)
        ) u_lane (
            .clk      (clk),
            .en       (lane_en),
            .mat      (mat_reg),
            .col_mode (col_mode_reg),
            .vec      (vec_reg),
            .total    (totals[i])
        );
    end

    hvt_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .clk    (clk),
        .en     (en[OUT_STAGE]),
        .totals (totals),
        .res    (res)
    );

    assign vector.ready = en[0];
    assign result.valid = valid_reg[OUT_STAGE];
    assign result.res_0 = res[0];
    assign result.res_1 = res[1];
    assign result.res_2 = res[2];
    assign result.res_3 = res[3];

endmodule

/* rtl/hvt_lane.sv */
module hvt_lane #(
    parameter int LANE_IDX = 0
) (
    input  logic               clk,
    input  hvt_pkg::lane_en_t  en,
    input  hvt_pkg::mat_regs_t mat,
    input  logic               col_mode,
    input  hvt_pkg::fix_vec_t  vec,
    output hvt_pkg::sum_t      total
);
    import hvt_pkg::*;

    fix_t                     coef [NUM_LANES];
    logic signed [PROD_W-1:0] prod_next [NUM_LANES];
    logic signed [PROD_W-1:0] prod_reg  [NUM_LANES];
    logic signed [PAIR_W-1:0] pair_next [2];
    logic signed [PAIR_W-1:0] pair_reg  [2];
    sum_t                     total_next;
    sum_t                     total_reg;

    always_comb
    begin
        for (int k = 0; k < NUM_LANES; k++)
        begin
            coef[k] = col_mode ?
                mat_entry(mat, LANE_IDX_W'(LANE_IDX), LANE_IDX_W'(k)) :
                mat_entry(mat, LANE_IDX_W'(k), LANE_IDX_W'(LANE_IDX));
            prod_next[k] = PROD_W'(vec[k]) * PROD_W'(coef[k]);
        end
        pair_next[0] = PAIR_W'(prod_reg[0]) + PAIR_W'(prod_reg[1]);
        pair_next[1] = PAIR_W'(prod_reg[2]) + PAIR_W'(prod_reg[3]);
        total_next   = SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]);
    end

    always_ff @(posedge clk)
    begin
        if (en.prod)
        begin
            prod_reg <= prod_next;
        end
        if (en.pair)
        begin
            pair_reg <= pair_next;
        end
        if (en.total)
        begin
            total_reg <= total_next;
        end
    end

    assign total = total_reg;

endmodule

/* rtl/hvt_merge.sv */
module hvt_merge #(
    parameter int FRAC_BITS = hvt_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              en,
    input  hvt_pkg::sum_vec_t totals,
    output hvt_pkg::fix_vec_t res
);
    import hvt_pkg::*;

    sum_t     shifted [NUM_LANES];
    fix_vec_t res_next;
    fix_vec_t res_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            shifted[i] = totals[i] >>> FRAC_BITS;
            if ((&shifted[i][SUM_W-1:DATA_W-1]) || !(|shifted[i][SUM_W-1:DATA_W-1]))
            begin
                res_next[i] = fix_t'(shifted[i][DATA_W-1:0]);
            end
            else
            begin
                res_next[i] = shifted[i][SUM_W-1] ? FIX_MIN : FIX_MAX;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

/* rtl/hvt_checker.sv */
`include "assert_macros.svh"

module hvt_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input hvt_pkg::fix_t res_0,
    input hvt_pkg::fix_t res_1,
    input hvt_pkg::fix_t res_2,
    input hvt_pkg::fix_t res_3
);

    // A stalled result keeps its transaction and its payload.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(res_0) && $stable(res_1) && $stable(res_2) && $stable(res_3))

    // With an empty output register no stage can be blocked.
    `ASSERT_SAME(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)

    // An accepted transaction reaches the output if the output is not stalled meanwhile.
    `ASSERT_NEXT(a_latency, clk, rst_n, in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready, out_valid)

endmodule

bind homogeneous_vector_transform hvt_checker u_hvt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vector.valid),
    .in_ready  (vector.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .res_0     (result.res_0),
    .res_1     (result.res_1),
    .res_2     (result.res_2),
    .res_3     (result.res_3)
);
